// ===== sv/sparse_tensor_block_histogram_macros.svh =====
// Assertion helpers for the histogram block; clock and reset are fixed names.
`ifndef SPARSE_TENSOR_BLOCK_HISTOGRAM_MACROS_SVH
`define SPARSE_TENSOR_BLOCK_HISTOGRAM_MACROS_SVH

// Condition implies consequence in the same cycle.
`define STBH_ASSERT_SAME(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define STBH_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/stbh_pkg.sv =====
`default_nettype none
package stbh_pkg;
   localparam int HIST_DEPTH_DEF  = 4096;
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int MAX_ORDER_DEF   = 5;

   localparam int NUM_DIMS = 5;

   // register indexes on the csr port
   localparam logic [2:0] REG_ORDER      = 3'd0;
   localparam logic [2:0] REG_GEOM_FIRST = 3'd1;
   localparam logic [2:0] REG_GEOM_LAST  = 3'd5;

   localparam logic [2:0]  ORDER_RESET = 3'd3;
   localparam logic [63:0] GEOM_RESET  = 64'h0000_0001_0000_0001;

   // request commands
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef logic [63:0] geom_type;
   typedef logic [31:0] coord_type;
endpackage
`default_nettype wire

// ===== sv/sparse_tensor_block_histogram.sv =====
// Block-sparse nonzero histogram.
// Requests are taken when start is high and busy is low. An add request
// (command 0) maps a COO entry to its block bin and increments it,
// saturating; a read request (command 1) returns one bin and clears it.
// Each request gives exactly one result, shown for one cycle on rsp_*
// with rsp_strobe; the receiver cannot stall, so results are never held.
// Zero-valued entries and reads of a bin beyond the histogram answer in
// the cycle after the transfer; other reads pass through the memory read
// and write states. For adds, each dimension runs two 33-step divisions
// (block count and block index) on one shared restoring divider, then a
// multiply and an accumulate step; unless the linear index falls outside
// the histogram, the bin update is then a read-modify-write of the count
// memory (one write port, one registered read port). One request is in
// flight at a time. Reset starts a clearing pass over the whole count
// memory; busy stays high through it. csr writes are taken at any time
// but must only be issued while the block is idle.
`default_nettype none
module sparse_tensor_block_histogram #(
   parameter int HIST_DEPTH  = stbh_pkg::HIST_DEPTH_DEF,
   parameter int COUNT_WIDTH = stbh_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_ORDER   = stbh_pkg::MAX_ORDER_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_command,
   input  wire stbh_pkg::coord_type     req_coord_a,
   input  wire stbh_pkg::coord_type     req_coord_b,
   input  wire stbh_pkg::coord_type     req_coord_c,
   input  wire stbh_pkg::coord_type     req_coord_d,
   input  wire stbh_pkg::coord_type     req_coord_e,
   input  wire logic [63:0]             req_value_bits,
   input  wire logic [11:0]             req_bin_select,
   output logic                         rsp_strobe,
   output logic [11:0]                  rsp_bin_index,
   output logic                         rsp_counted,
   output logic                         rsp_out_of_range,
   output logic [31:0]                  rsp_bin_count,
   input  wire logic                    csr_we,
   input  wire logic [2:0]              csr_index,
   input  wire logic [63:0]             csr_wdata
);
   import stbh_pkg::*;

   localparam int AW = $clog2(HIST_DEPTH);
   localparam int SW = $clog2(HIST_DEPTH + 1);
   localparam int PW = 2 * SW;
   localparam logic [SW-1:0]  DEPTH_S = SW'(HIST_DEPTH);
   localparam logic [32:0]    DEPTH_W = 33'(HIST_DEPTH);
   localparam logic [PW:0]    DEPTH_P = (PW+1)'(HIST_DEPTH);
   localparam logic [AW-1:0]  LAST_ADDR = AW'(HIST_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [2:0] MAX_ORD = 3'(MAX_ORDER);
   localparam logic [5:0] LAST_STEP = 6'd33;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIVN  = 3'd2;
   localparam logic [2:0] S_DIVQ  = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_ACC   = 3'd5;
   localparam logic [2:0] S_MEMRD = 3'd6;
   localparam logic [2:0] S_MEMWR = 3'd7;

   // configuration
   logic [2:0]  order_ff;
   geom_type    geom_ff [NUM_DIMS];

   // sequencer state
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          cmd_ff, cmd_in;
   coord_type     coord_ff [NUM_DIMS];
   logic [2:0]    dim_ff, dim_in;
   logic [5:0]    step_ff, step_in;
   logic [31:0]   rem_ff, rem_in;
   logic [32:0]   quo_ff, quo_in;
   logic [32:0]   n_ff, n_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0] sprod_ff, sprod_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] stride_ff, stride_in;
   logic [AW-1:0] addr_ff, addr_in;

   // result registers
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [11:0]   rsp_index_ff, rsp_index_in;
   logic          rsp_counted_ff, rsp_counted_in;
   logic          rsp_oor_ff, rsp_oor_in;
   logic [31:0]   rsp_count_ff, rsp_count_in;

   // count memory
   logic [COUNT_WIDTH-1:0] mem [HIST_DEPTH];
   logic [COUNT_WIDTH-1:0] rd_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_wa;
   logic [COUNT_WIDTH-1:0] mem_wd;

   // datapath helpers
   geom_type      geom_cur;
   logic [31:0]   bsize;
   logic [32:0]   trial;
   logic          fits;
   logic [2:0]    act_order;
   logic [32:0]   pblk;
   logic [SW-1:0] p_c, n_c;
   logic [PW:0]   isum;
   logic          accept;
   logic [COUNT_WIDTH-1:0] incr;

   assign accept   = start && (state_ff == S_IDLE);
   assign geom_cur = geom_ff[dim_ff];
   assign bsize    = (geom_cur[63:32] == 32'd0) ? 32'd1 : geom_cur[63:32];

   // one restoring divide step
   assign trial = {rem_ff, quo_ff[32]};
   assign fits  = trial >= {1'b0, bsize};

   always_comb begin
      if (order_ff == 3'd0) begin
         act_order = 3'd1;
      end else if (order_ff > MAX_ORD) begin
         act_order = MAX_ORD;
      end else begin
         act_order = order_ff;
      end
   end

   // block index of the current dimension, clamped, then capped at the depth
   always_comb begin
      if (coord_ff[dim_ff] == 32'd0 || quo_ff >= n_ff) begin
         pblk = n_ff - 33'd1;
      end else begin
         pblk = quo_ff;
      end
      p_c  = (pblk >= DEPTH_W) ? DEPTH_S : SW'(pblk);
      n_c  = (n_ff >= DEPTH_W) ? DEPTH_S : SW'(n_ff);
      isum = {1'b0, PW'(idx_ff)} + {1'b0, prod_ff};
   end

   assign incr = (rd_ff == COUNT_MAX) ? rd_ff : rd_ff + 1'b1;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cmd_in     = cmd_ff;
      dim_in     = dim_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      n_in       = n_ff;
      prod_in    = prod_ff;
      sprod_in   = sprod_ff;
      idx_in     = idx_ff;
      stride_in  = stride_ff;
      addr_in    = addr_ff;
      rsp_strobe_in  = 1'b0;
      rsp_index_in   = rsp_index_ff;
      rsp_counted_in = 1'b0;
      rsp_oor_in     = 1'b0;
      rsp_count_in   = rsp_count_ff;
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_command;
               if (req_command == CMD_READ) begin
                  if ({20'd0, req_bin_select} >= 32'(HIST_DEPTH)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_index_in  = req_bin_select;
                     rsp_oor_in    = 1'b1;
                     rsp_count_in  = 32'd0;
                  end else begin
                     addr_in  = AW'(req_bin_select);
                     state_in = S_MEMRD;
                  end
               end else if (req_value_bits[62:0] == 63'd0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_index_in  = 12'd0;
                  rsp_count_in  = 32'd0;
               end else begin
                  dim_in    = act_order - 3'd1;
                  idx_in    = '0;
                  stride_in = SW'(1);
                  step_in   = 6'd0;
                  state_in  = S_DIVN;
               end
            end
         end
         S_DIVN, S_DIVQ: begin
            if (step_ff == 6'd0) begin
               rem_in = 32'd0;
               if (state_ff == S_DIVN) begin
                  quo_in = {1'b0, geom_cur[31:0]} + {1'b0, bsize} - 33'd1;
               end else begin
                  quo_in = {1'b0, coord_ff[dim_ff] - 32'd1};
               end
            end else begin
               rem_in = fits ? 32'(trial - {1'b0, bsize}) : trial[31:0];
               quo_in = {quo_ff[31:0], fits};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == LAST_STEP) begin
               step_in = 6'd0;
               if (state_ff == S_DIVN) begin
                  n_in     = (quo_in == 33'd0) ? 33'd1 : quo_in;
                  state_in = S_DIVQ;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_in  = PW'(p_c) * PW'(stride_ff);
            sprod_in = PW'(n_c) * PW'(stride_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            idx_in    = (isum >= DEPTH_P) ? DEPTH_S : SW'(isum);
            stride_in = ({1'b0, sprod_ff} >= DEPTH_P) ? DEPTH_S : SW'(sprod_ff);
            if (dim_ff == 3'd0) begin
               if (isum >= DEPTH_P) begin
                  rsp_strobe_in = 1'b1;
                  rsp_index_in  = 12'd0;
                  rsp_oor_in    = 1'b1;
                  rsp_count_in  = 32'd0;
                  state_in      = S_IDLE;
               end else begin
                  addr_in  = AW'(isum);
                  state_in = S_MEMRD;
               end
            end else begin
               dim_in   = dim_ff - 3'd1;
               state_in = S_DIVN;
            end
         end
         S_MEMRD: begin
            state_in = S_MEMWR;
         end
         S_MEMWR: begin
            mem_we        = 1'b1;
            mem_wd        = (cmd_ff == CMD_READ) ? '0 : incr;
            rsp_strobe_in = 1'b1;
            rsp_index_in  = 12'(addr_ff);
            rsp_counted_in = (cmd_ff == CMD_ADD);
            rsp_count_in  = (cmd_ff == CMD_READ) ? 32'(rd_ff) : 32'(incr);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         rsp_strobe_ff  <= 1'b0;
         rsp_counted_ff <= 1'b0;
         rsp_oor_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_counted_ff <= rsp_counted_in;
         rsp_oor_ff     <= rsp_oor_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      dim_ff       <= dim_in;
      step_ff      <= step_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      n_ff         <= n_in;
      prod_ff      <= prod_in;
      sprod_ff     <= sprod_in;
      idx_ff       <= idx_in;
      stride_ff    <= stride_in;
      addr_ff      <= addr_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
      if (accept) begin
         coord_ff[0] <= req_coord_a;
         coord_ff[1] <= req_coord_b;
         coord_ff[2] <= req_coord_c;
         coord_ff[3] <= req_coord_d;
         coord_ff[4] <= req_coord_e;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         for (int k = 0; k < NUM_DIMS; k++) begin
            geom_ff[k] <= GEOM_RESET;
         end
      end else if (csr_we) begin
         if (csr_index == REG_ORDER) begin
            order_ff <= csr_wdata[2:0];
         end else if (csr_index >= REG_GEOM_FIRST && csr_index <= REG_GEOM_LAST) begin
            geom_ff[csr_index - REG_GEOM_FIRST] <= csr_wdata;
         end
      end
   end

   // count memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[addr_ff];
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_bin_index    = rsp_index_ff;
   assign rsp_counted      = rsp_counted_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_bin_count    = rsp_count_ff;

`include "sparse_tensor_block_histogram_macros.svh"
   `STBH_ASSERT_SAME(a_counted_in_range, rsp_counted_ff, !rsp_oor_ff && rsp_strobe_ff, "counted with out of range")
   `STBH_ASSERT_SAME(a_no_rsp_in_clear, state_ff == S_CLEAR, !rsp_strobe_ff, "result during clear")
   `STBH_ASSERT_NEXT(a_memwr_responds, state_ff == S_MEMWR, rsp_strobe_ff && !busy, "memory update gave no result")
endmodule
`default_nettype wire
